// File: hw/rtl/lzbd_pkg.sv
// lzbd_pkg: shared types and constants for the lzss byte stream decoder
// no dependencies; imported by lzbd_window and lzss_byte_stream_decoder_unit

package lzbd_pkg;

  localparam int unsigned CODE_W   = 8;   // payload byte width
  localparam int unsigned REFPOS_W = 12;  // position field width in a reference
  localparam int unsigned LEN_W    = 5;   // holds a run length of 3 to 18

  localparam logic [REFPOS_W-1:0] START_RESET = 12'hFEE;
  localparam logic [LEN_W-1:0]    LEN_BIAS    = 5'd3;

  // decoder sequencer states; flag, item and high are the stream phases
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_FLAG,
    ST_ITEM,
    ST_HIGH,
    ST_COPY
  } lzbd_state_e;

endpackage

// File: hw/rtl/lzbd_window.sv
// lzbd_window: history window memory, one write and one read port, registered read
// forwards a write that lands on the address read in the same cycle; uses lzbd_pkg

module lzbd_window
  import lzbd_pkg::*;
#(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CODE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CODE_W-1:0] rdata_o
);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rdata_q;
  logic [CODE_W-1:0] fwd_data_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q    <= mem[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

// File: hw/rtl/lzss_byte_stream_decoder_unit.sv
// lzss_byte_stream_decoder_unit: top level of the lzss byte stream decoder
// depends on lzbd_pkg and lzbd_window
//
//   channel   direction  signals                               handshake
//   -------   ---------  ------------------------------------  ---------------
//   in        input      code_byte_i                           in_valid_i/in_ready_o
//   out       output     out_byte_o, run_last_o                out_valid_o/out_ready_i
//   cfg       input      cfg_wdata_i (start position)          cfg_we_i, no wait
//
// input: a flag or low reference byte is always taken, a literal while the output
//   register is free; a high reference byte holds the input during its copy, which
//   reads the window's single read port, one byte per cycle unless the output stalls
// reset: after rst_ni rises, a clearing pass writes zero to all WINDOW_DEPTH
//   entries, one per cycle; no input is taken until it ends
// stalls: a held output register parts the two sides; a copy pauses with its
//   fetched byte held while the output register is full and out_ready_i is low

module lzss_byte_stream_decoder_unit
  import lzbd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CODE_W-1:0]   code_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CODE_W-1:0]   out_byte_o,
  output logic                run_last_o,
  input  logic                cfg_we_i,
  input  logic [REFPOS_W-1:0] cfg_wdata_i
);

  // window address width and a wide enough width for the wrap reduction
  localparam int unsigned PW = $clog2(WINDOW_DEPTH);
  localparam int unsigned RW = PW + 4;
  localparam logic [RW-1:0] DEPTH_W  = RW'(WINDOW_DEPTH);
  localparam logic [PW-1:0] LAST_POS = PW'(WINDOW_DEPTH - 1);
  localparam logic [PW-1:0] START_WP = PW'(START_RESET % WINDOW_DEPTH);

  // 12-bit position taken modulo the window depth; four restoring steps cover a value
  // below 16 depths, which holds for a WINDOW_DEPTH of at least 256
  function automatic logic [PW-1:0] wrap_pos(input logic [REFPOS_W-1:0] x);
    logic [RW-1:0] r;
    r = RW'(x);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (DEPTH_W << k)) begin
        r = r - (DEPTH_W << k);
      end
    end
    return r[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  lzbd_state_e state_q, state_d;

  logic [PW-1:0]     wr_pos_q, wr_pos_d;      // window write position
  logic [PW-1:0]     rd_pos_q, rd_pos_d;      // copy source position
  logic [PW-1:0]     clr_pos_q, clr_pos_d;    // clearing pass position
  logic [LEN_W-1:0]  rd_cnt_q, rd_cnt_d;      // reads still to issue
  logic [CODE_W-1:0] flags_q, flags_d;
  logic [2:0]        flag_idx_q, flag_idx_d;
  logic [CODE_W-1:0] held_low_q, held_low_d;
  logic              dv_q, dv_d;              // fetched byte waiting to commit
  logic              dlast_q, dlast_d;        // that byte ends the run
  logic              out_valid_q, out_valid_d;
  logic [CODE_W-1:0] out_byte_q, out_byte_d;
  logic              run_last_q, run_last_d;

  // window port
  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic [CODE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CODE_W-1:0] mem_rdata;

  logic              out_free;
  logic              in_xfer;
  logic              flag_bit;
  logic              copy_issue;
  logic              copy_commit;
  logic [2:0]        idx_inc;
  lzbd_state_e       after_item;
  logic [REFPOS_W-1:0] ref_pos;

  lzbd_window #(
    .DEPTH  (WINDOW_DEPTH),
    .ADDR_W (PW)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_pos_q),
    .rdata_o (mem_rdata)
  );

  // shared control terms
  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    flag_bit    = flags_q[flag_idx_q];
    idx_inc     = flag_idx_q + 3'd1;
    after_item  = (idx_inc == 3'd0) ? ST_FLAG : ST_ITEM;
    // commit a fetched byte when the output register frees up
    copy_commit = (state_q == ST_COPY) && dv_q && out_free;
    // next read only when the data stage is empty or drains this cycle
    copy_issue  = (state_q == ST_COPY) && (rd_cnt_q != '0) && (!dv_q || copy_commit);
    ref_pos     = {code_byte_i[7:4], held_low_q};
    case (state_q)
      ST_FLAG: in_ready_o = 1'b1;
      ST_ITEM: in_ready_o = flag_bit ? out_free : 1'b1;
      ST_HIGH: in_ready_o = 1'b1;
      default: in_ready_o = 1'b0;
    endcase
    in_xfer = in_valid_i && in_ready_o;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_pos_q == LAST_POS) state_d = ST_FLAG;
      end
      ST_FLAG: begin
        if (in_xfer) state_d = ST_ITEM;
      end
      ST_ITEM: begin
        if (in_xfer) state_d = flag_bit ? after_item : ST_HIGH;
      end
      ST_HIGH: begin
        if (in_xfer) state_d = ST_COPY;
      end
      ST_COPY: begin
        if (copy_commit && dlast_q) state_d = after_item;
      end
      default: state_d = ST_FLAG;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wr_pos_d    = wr_pos_q;
    rd_pos_d    = rd_pos_q;
    clr_pos_d   = clr_pos_q;
    rd_cnt_d    = rd_cnt_q;
    flags_d     = flags_q;
    flag_idx_d  = flag_idx_q;
    held_low_d  = held_low_q;
    dv_d        = dv_q;
    dlast_d     = dlast_q;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = wr_pos_q;
    mem_wdata   = code_byte_i;
    mem_re      = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_pos_q;
        mem_wdata = '0;
        clr_pos_d = clr_pos_q + 1'b1;
      end
      ST_FLAG: begin
        if (in_xfer) begin
          flags_d    = code_byte_i;
          flag_idx_d = 3'd0;
        end
      end
      ST_ITEM: begin
        if (in_xfer) begin
          if (flag_bit) begin
            // literal: store, emit as a run of one
            mem_we      = 1'b1;
            wr_pos_d    = next_pos(wr_pos_q);
            out_valid_d = 1'b1;
            out_byte_d  = code_byte_i;
            run_last_d  = 1'b1;
            flag_idx_d  = idx_inc;
          end else begin
            held_low_d = code_byte_i;
          end
        end
      end
      ST_HIGH: begin
        if (in_xfer) begin
          rd_pos_d = wrap_pos(ref_pos);
          rd_cnt_d = LEN_W'(code_byte_i[3:0]) + LEN_BIAS;
          dv_d     = 1'b0;
        end
      end
      ST_COPY: begin
        if (copy_commit) begin
          mem_we      = 1'b1;
          mem_wdata   = mem_rdata;
          wr_pos_d    = next_pos(wr_pos_q);
          out_valid_d = 1'b1;
          out_byte_d  = mem_rdata;
          run_last_d  = dlast_q;
          dv_d        = 1'b0;
          if (dlast_q) flag_idx_d = idx_inc;
        end
        if (copy_issue) begin
          mem_re   = 1'b1;
          rd_pos_d = next_pos(rd_pos_q);
          rd_cnt_d = rd_cnt_q - 1'b1;
          dv_d     = 1'b1;
          dlast_d  = (rd_cnt_q == LEN_W'(1));
        end
      end
      default: ;
    endcase

    // start position write reloads the write position at once
    if (cfg_we_i) begin
      wr_pos_d = wrap_pos(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wr_pos_q    <= START_WP;
      clr_pos_q   <= '0;
      rd_cnt_q    <= '0;
      flags_q     <= '0;
      flag_idx_q  <= 3'd0;
      held_low_q  <= '0;
      dv_q        <= 1'b0;
      dlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_pos_q    <= wr_pos_d;
      clr_pos_q   <= clr_pos_d;
      rd_cnt_q    <= rd_cnt_d;
      flags_q     <= flags_d;
      flag_idx_q  <= flag_idx_d;
      held_low_q  <= held_low_d;
      dv_q        <= dv_d;
      dlast_q     <= dlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_pos_q   <= rd_pos_d;
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

endmodule
